// ===== hw/rtl/poly_voice_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared concurrent assertion shorthands for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_MACROS_SVH

// checked only while out of reset
`define PVA_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("pva assertion failed");

// checked on every edge, reset included
`define PVA_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("pva reset assertion failed");

`endif

// ===== hw/rtl/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// Voice allocator package
// Field widths, codes, pick result type and note math helpers.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int MASK_W = 12;
  localparam int PICK_W = 4;
  localparam int NOTE_W = 7;
  localparam int OCT_W  = 5;
  localparam int FREQ_W = 11;
  localparam int CHIP_CH_W = 3;

  localparam logic KIND_NOTE_ON  = 1'b0;
  localparam logic KIND_NOTE_OFF = 1'b1;

  localparam logic ACT_KEY_ON  = 1'b0;
  localparam logic ACT_KEY_OFF = 1'b1;

  typedef struct packed {
    logic              ok;
    logic [PICK_W-1:0] chan;
  } pick_t;

  // floor(note / 12) for 7-bit notes: 171 / 2048 is close enough over 0..127
  function automatic logic [3:0] note_div12(input logic [NOTE_W-1:0] note);
    logic [14:0] prod;
    prod = 15'(note) * 15'd171;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] note_rem12(input logic [NOTE_W-1:0] note);
    logic [NOTE_W-1:0] base;
    base = NOTE_W'(note_div12(note)) * 7'd12;
    return 4'(note - base);
  endfunction

  function automatic logic [FREQ_W-1:0] tune_lookup(input logic [3:0] semi);
    logic [FREQ_W-1:0] f;
    unique case (semi)
      4'd0:    f = 11'd686;
      4'd1:    f = 11'd727;
      4'd2:    f = 11'd770;
      4'd3:    f = 11'd816;
      4'd4:    f = 11'd865;
      4'd5:    f = 11'd916;
      4'd6:    f = 11'd970;
      4'd7:    f = 11'd1028;
      4'd8:    f = 11'd1089;
      4'd9:    f = 11'd1154;
      4'd10:   f = 11'd1223;
      4'd11:   f = 11'd1295;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/pva_in_if.sv =====
// ----------------------------------------------------------------------------
// Note event channel
// Valid/ready channel carrying one note-on or note-off word.
// ----------------------------------------------------------------------------
interface pva_in_if
  import pva_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [NOTE_W-1:0] note;

  modport source (output valid, kind, note, input ready);
  modport sink   (input valid, kind, note, output ready);
endinterface

// ===== hw/rtl/pva_out_if.sv =====
// ----------------------------------------------------------------------------
// Key event channel
// Valid/ready channel carrying one key-on or key-off word.
// ----------------------------------------------------------------------------
interface pva_out_if
  import pva_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic                    chip_index;
  logic [CHIP_CH_W-1:0]    chip_channel;
  logic signed [OCT_W-1:0] octave;
  logic [FREQ_W-1:0]       freq_number;

  modport source (output valid, action, chip_index, chip_channel, octave, freq_number,
                  input ready);
  modport sink   (input valid, action, chip_index, chip_channel, octave, freq_number,
                  output ready);
endinterface

// ===== hw/rtl/pva_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Channel mask write channel
// Valid/ready channel carrying the channel enable mask.
// ----------------------------------------------------------------------------
interface pva_cfg_if
  import pva_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] channel_mask;

  modport source (output valid, channel_mask, input ready);
  modport sink   (input valid, channel_mask, output ready);
endinterface

// ===== hw/rtl/poly_voice_allocator.sv =====
// Note-on: accept, pick/append, emit -> key-on word; no word when no enabled free
//   channel can be picked.
// Note-off: each held entry goes through the RAM read port (search, then
//   shift-down), then finish and emit -> key-off word; no word when the note is
//   not held. One word in flight; emit waits for room.
// Reset (rst_n low, synchronous): list empty, all channels free, channel mask 0.
// ----------------------------------------------------------------------------
// Polyphonic voice allocator
// First-free channel allocation with an ordered held-note list in RAM.
// ----------------------------------------------------------------------------
module poly_voice_allocator
  import pva_pkg::*;
#(
  parameter int NUM_CHANNELS  = 12,
  parameter int CHIP_CHANNELS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  pva_in_if.sink    in_if,
  pva_out_if.source out_if,
  pva_cfg_if.sink   cfg_if
);

  localparam int AW     = $clog2(NUM_CHANNELS);
  localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);
  localparam int WORD_W = NOTE_W + AW;

  pick_t                   pick;
  logic [MASK_W-1:0]       channel_mask;
  logic [NUM_CHANNELS-1:0] busy;
  logic [CNT_W-1:0]        held_count;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [WORD_W-1:0]       ram_rdata;

  pva_ctrl #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .CHIP_CHANNELS (CHIP_CHANNELS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_if        (in_if),
    .out_if       (out_if),
    .cfg_if       (cfg_if),
    .pick         (pick),
    .channel_mask (channel_mask),
    .busy         (busy),
    .held_count   (held_count),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  pva_pick #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_pick (
    .channel_mask (channel_mask),
    .busy         (busy),
    .held_count   (held_count),
    .pick         (pick)
  );

  pva_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_CHANNELS)
  ) u_held_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== hw/rtl/pva_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pva_pick.sv =====
// ----------------------------------------------------------------------------
// Channel picker
// Finds the lowest enabled free channel and flags a full voice.
// ----------------------------------------------------------------------------
module pva_pick
  import pva_pkg::*;
#(
  parameter int NUM_CHANNELS = 12
) (
  input  logic [MASK_W-1:0]                    channel_mask,
  input  logic [NUM_CHANNELS-1:0]              busy,
  input  logic [$clog2(NUM_CHANNELS+1)-1:0]    held_count,
  output pick_t                                pick
);

  localparam int NUM_USED = (NUM_CHANNELS < MASK_W) ? NUM_CHANNELS : MASK_W;
  localparam logic [MASK_W-1:0] USED_MASK = MASK_W'((32'd1 << NUM_USED) - 32'd1);

  logic [MASK_W-1:0] busy_w;
  logic [MASK_W-1:0] en;
  logic [MASK_W-1:0] free;
  logic [3:0]        pop;
  logic [PICK_W-1:0] first;
  logic              any_free;
  logic              full;

  if (NUM_CHANNELS >= MASK_W) begin : g_busy_trunc
    assign busy_w = busy[MASK_W-1:0];
  end else begin : g_busy_ext
    assign busy_w = MASK_W'(busy);
  end

  assign en   = channel_mask & USED_MASK;
  assign free = en & ~busy_w;

  always_comb begin
    pop = '0;
    for (int i = 0; i < MASK_W; i++) begin
      pop = pop + 4'(en[i]);
    end
  end

  // scan down so the lowest free channel wins
  always_comb begin
    first = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (free[i]) begin
        first = PICK_W'(i);
      end
    end
  end

  assign any_free = |free;
  assign full = (32'(held_count) >= 32'(pop)) || (32'(held_count) >= NUM_CHANNELS);

  assign pick.ok   = any_free && !full;
  assign pick.chan = first;

endmodule

// ===== hw/rtl/pva_ctrl.sv =====
// ----------------------------------------------------------------------------
// Voice allocator control
// Sequencer over the held-note RAM: append, search, shift-down and emit.
// ----------------------------------------------------------------------------
module pva_ctrl
  import pva_pkg::*;
#(
  parameter int NUM_CHANNELS  = 12,
  parameter int CHIP_CHANNELS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pva_in_if.sink                               in_if,
  pva_out_if.source                            out_if,
  pva_cfg_if.sink                              cfg_if,
  input  pick_t                                pick,
  output logic [MASK_W-1:0]                    channel_mask,
  output logic [NUM_CHANNELS-1:0]              busy,
  output logic [$clog2(NUM_CHANNELS+1)-1:0]    held_count,
  output logic                                 ram_we,
  output logic [$clog2(NUM_CHANNELS)-1:0]      ram_waddr,
  output logic [NOTE_W+$clog2(NUM_CHANNELS)-1:0] ram_wdata,
  output logic                                 ram_re,
  output logic [$clog2(NUM_CHANNELS)-1:0]      ram_raddr,
  input  logic [NOTE_W+$clog2(NUM_CHANNELS)-1:0] ram_rdata
);

  localparam int AW     = $clog2(NUM_CHANNELS);
  localparam int CH_W   = AW;
  localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);
  localparam int WORD_W = NOTE_W + CH_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ON,
    S_OFF_START,
    S_SCAN,
    S_SHIFT,
    S_FINISH,
    S_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [MASK_W-1:0]       mask_r, mask_nxt;
  logic [NUM_CHANNELS-1:0] busy_r, busy_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [NOTE_W-1:0]       note_r, note_nxt;
  logic [CH_W-1:0]         chan_r, chan_nxt;
  logic                    act_r, act_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_action_r, out_action_nxt;
  logic                    out_chip_r, out_chip_nxt;
  logic [CHIP_CH_W-1:0]    out_chch_r, out_chch_nxt;
  logic signed [OCT_W-1:0] out_oct_r, out_oct_nxt;
  logic [FREQ_W-1:0]       out_freq_r, out_freq_nxt;

  logic [CNT_W-1:0]        idx_inc;
  logic [CNT_W-1:0]        idx_dec;
  logic                    more;
  logic [NOTE_W-1:0]       rd_note;
  logic [CH_W-1:0]         rd_chan;
  logic [CH_W-1:0]         pick_chan;
  logic [3:0]              chip_q;
  logic [31:0]             chip_rem;

  assign idx_inc   = idx_r + CNT_W'(1);
  assign idx_dec   = idx_r - CNT_W'(1);
  assign more      = idx_inc < count_r;
  assign rd_note   = ram_rdata[WORD_W-1 -: NOTE_W];
  assign rd_chan   = ram_rdata[CH_W-1:0];
  assign pick_chan = CH_W'(pick.chan);

  // channel -> chip / channel-in-chip, by compare against multiples
  always_comb begin
    chip_q = '0;
    for (int k = 1; k < 16; k++) begin
      if (32'(chan_r) >= k * CHIP_CHANNELS) begin
        chip_q = 4'(k);
      end
    end
    chip_rem = 32'(chan_r) - 32'(chip_q) * CHIP_CHANNELS;
  end

  always_comb begin
    state_nxt      = state_r;
    mask_nxt       = mask_r;
    busy_nxt       = busy_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    note_nxt       = note_r;
    chan_nxt       = chan_r;
    act_nxt        = act_r;
    out_valid_nxt  = out_valid_r;
    out_action_nxt = out_action_r;
    out_chip_nxt   = out_chip_r;
    out_chch_nxt   = out_chch_r;
    out_oct_nxt    = out_oct_r;
    out_freq_nxt   = out_freq_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    if (cfg_if.valid) begin
      mask_nxt = cfg_if.channel_mask;
    end
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          note_nxt  = in_if.note;
          state_nxt = (in_if.kind == KIND_NOTE_ON) ? S_ON : S_OFF_START;
        end
      end
      S_ON: begin
        if (pick.ok) begin
          ram_we              = 1'b1;
          ram_waddr           = count_r[AW-1:0];
          ram_wdata           = {note_r, pick_chan};
          count_nxt           = count_r + CNT_W'(1);
          busy_nxt[pick_chan] = 1'b1;
          chan_nxt            = pick_chan;
          act_nxt             = ACT_KEY_ON;
          state_nxt           = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OFF_START: begin
        idx_nxt = '0;
        if (count_r != '0) begin
          ram_re    = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (rd_note == note_r) begin
          chan_nxt = rd_chan;
          if (more) begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc[AW-1:0];
            idx_nxt   = idx_inc;
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (more) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
          idx_nxt   = idx_inc;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        // entry idx moves down one; read of idx+1 never hits the written slot
        ram_we    = 1'b1;
        ram_waddr = idx_dec[AW-1:0];
        ram_wdata = ram_rdata;
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
          idx_nxt   = idx_inc;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        count_nxt        = count_r - CNT_W'(1);
        busy_nxt[chan_r] = 1'b0;
        act_nxt          = ACT_KEY_OFF;
        state_nxt        = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = act_r;
          out_chip_nxt   = chip_q[0];
          out_chch_nxt   = chip_rem[CHIP_CH_W-1:0];
          if (act_r == ACT_KEY_ON) begin
            out_oct_nxt  = OCT_W'(note_div12(note_r)) - OCT_W'(1);
            out_freq_nxt = tune_lookup(note_rem12(note_r));
          end else begin
            out_oct_nxt  = '0;
            out_freq_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= '0;
      busy_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    note_r       <= note_nxt;
    chan_r       <= chan_nxt;
    act_r        <= act_nxt;
    out_action_r <= out_action_nxt;
    out_chip_r   <= out_chip_nxt;
    out_chch_r   <= out_chch_nxt;
    out_oct_r    <= out_oct_nxt;
    out_freq_r   <= out_freq_nxt;
  end

  assign in_if.ready         = (state_r == S_IDLE);
  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.action       = out_action_r;
  assign out_if.chip_index   = out_chip_r;
  assign out_if.chip_channel = out_chch_r;
  assign out_if.octave       = out_oct_r;
  assign out_if.freq_number  = out_freq_r;

  assign channel_mask = mask_r;
  assign busy         = busy_r;
  assign held_count   = count_r;

endmodule

// ===== hw/rtl/pva_checker.sv =====
// ----------------------------------------------------------------------------
// Voice allocator checker
// Port-level assertions, bound to the allocator top level.
// ----------------------------------------------------------------------------
`include "poly_voice_allocator_macros.svh"

module pva_checker
  import pva_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_action,
  input logic signed [OCT_W-1:0] out_octave,
  input logic [FREQ_W-1:0]       out_freq_number
);

  // one word in flight: no accept right after an accept
  `PVA_ASSERT(a_one_in_flight, clk, rst_n, (in_valid && in_ready) |=> !in_ready)

  // key-off words carry no pitch
  `PVA_ASSERT(a_key_off_zero, clk, rst_n, (out_valid && out_action == ACT_KEY_OFF) |-> (out_octave == '0 && out_freq_number == '0))

  // key-on words always carry a tuning value
  `PVA_ASSERT(a_key_on_freq, clk, rst_n, (out_valid && out_action == ACT_KEY_ON) |-> (out_freq_number != '0))

  `PVA_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_action) && $stable(out_freq_number)))

  `PVA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_action      (out_if.action),
  .out_octave      (out_if.octave),
  .out_freq_number (out_if.freq_number)
);
